[sv/i2ctw_pkg.sv]
package i2ctw_pkg;

    // Shared divider width
    localparam int DIV_W       = 32;
    localparam int DIV_COUNT_W = $clog2(DIV_W + 1);

    // Field widths
    localparam int SPEED_W = 20;
    localparam int WORD_W  = 32;
    localparam int CFG_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int PRESC_W = 4;
    localparam int TICKS_W = 9;
    localparam int SHIFT_W = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_SOURCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AHB_PRESCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_APB_PRESCALE = 2'd2;

    // Clock source code that selects the fast clock
    localparam logic [1:0] CLK_SRC_PLL = 2'd2;

    // Arithmetic constants
    localparam logic [DIV_W-1:0]   NS_PER_SEC     = 32'd1000000000;
    localparam logic [DIV_W-1:0]   SYS_CLK_SLOW   = 32'd8000000;
    localparam logic [DIV_W-1:0]   SYS_CLK_FAST   = 32'd48000000;
    localparam logic [DIV_W-1:0]   MAX_TICKS      = 32'd510;
    localparam logic [SPEED_W-1:0] STD_MODE_LIMIT = 20'd100000;
    localparam logic [TICKS_W-1:0] FIELD_MAX      = 9'd255;
    localparam logic [DIV_W-1:0]   SPLIT_DIVISOR  = 32'd3;
    localparam logic [PRESC_W-1:0] PRESC_LAST     = 4'd15;
    localparam logic [3:0]         CDEL_STD       = 4'd3;
    localparam logic [3:0]         CDEL_FAST      = 4'd2;

    // Division by three as a reciprocal multiply: exact for dividends below 1536 in the 20-bit product
    localparam int                  SPLIT_PROD_W = 20;
    localparam int                  SPLIT_SHIFT  = 11;
    localparam logic [SPLIT_PROD_W-1:0] SPLIT_RECIP = 20'd683;

    // Request to the shared divider
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    // Response from the shared divider
    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    // AHB divider as a right shift: codes below 8 do not divide
    function automatic logic [SHIFT_W-1:0] ahb_shift(input logic [3:0] code);
        logic [SHIFT_W-1:0] s;
        case (code)
            4'd8:    s = 4'd1;
            4'd9:    s = 4'd2;
            4'd10:   s = 4'd3;
            4'd11:   s = 4'd4;
            4'd12:   s = 4'd6;
            4'd13:   s = 4'd7;
            4'd14:   s = 4'd8;
            4'd15:   s = 4'd9;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

    // APB divider as a right shift: codes below 4 do not divide
    function automatic logic [SHIFT_W-1:0] apb_shift(input logic [2:0] code);
        logic [SHIFT_W-1:0] s;
        case (code)
            3'd4:    s = 4'd1;
            3'd5:    s = 4'd2;
            3'd6:    s = 4'd3;
            3'd7:    s = 4'd4;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

endpackage

[sv/i2ctw_div.sv]
module i2ctw_div
    import i2ctw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_COUNT_W-1:0] count_reg, count_next;
    logic                   done_reg, done_next;
    logic [DIV_W-1:0]       rem_reg, rem_next;
    logic [DIV_W-1:0]       quo_reg, quo_next;
    logic [DIV_W-1:0]       dvs_reg, dvs_next;
    logic [DIV_W:0]         shifted;
    logic [DIV_W:0]         trial;

    // Shift in one dividend bit and try the subtraction
    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        count_next = count_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        if (req.start)
        begin
            // Load operands and run one quotient bit per cycle
            count_next = DIV_COUNT_W'(DIV_W);
            rem_next   = '0;
            quo_next   = req.dividend;
            dvs_next   = req.divisor;
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - 1'b1;
            done_next  = (count_reg == DIV_COUNT_W'(1));
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    // Hold the iteration count and the done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Hold the datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[sv/i2c_timing_word_calculator_core.sv]
// Takes a requested I2C bus speed in hertz and returns one packed timing word
// and a possible flag per request, from the clock source and the AHB and APB
// prescaler registers. All divisions run on one shared 32-bit restoring
// divider that yields one quotient bit per cycle. A request with a nonzero
// speed needs 3 to 18 divisions: clock period, bus period, and one per
// prescaler tried (1 to 16); the two-thirds low/high split is a reciprocal
// multiply in its own state after the last division. A zero speed gives an
// impossible result with no division. in_stall is high from acceptance until
// the result is loaded into the output register; one finished result may wait
// there while the next request is computed. Write the registers only while no
// request is in flight.
module i2c_timing_word_calculator_core
    import i2ctw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [SPEED_W-1:0]   speed_hz,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [WORD_W-1:0]    timing_word,
    output logic                 possible
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLK,
        ST_BUS,
        ST_TICK,
        ST_SPLIT,
        ST_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [1:0]           clk_src_reg;
    logic [3:0]           ahb_code_reg;
    logic [2:0]           apb_code_reg;
    logic                 start_reg, start_next;
    logic                 out_valid_reg, out_valid_next;
    logic [DIV_W-1:0]     dividend_reg, dividend_next;
    logic [DIV_W-1:0]     divisor_reg, divisor_next;
    logic [SPEED_W-1:0]   speed_reg, speed_next;
    logic [DIV_W-1:0]     clk_ns_reg, clk_ns_next;
    logic [DIV_W-1:0]     bus_ns_reg, bus_ns_next;
    logic [DIV_W-1:0]     acc_reg, acc_next;
    logic [PRESC_W-1:0]   presc_reg, presc_next;
    logic [TICKS_W-1:0]   ticks_reg, ticks_next;
    logic [WORD_W-1:0]    res_word_reg, res_word_next;
    logic                 res_ok_reg, res_ok_next;
    logic [WORD_W-1:0]    word_reg, word_next;
    logic                 possible_reg, possible_next;
    logic [DIV_W-1:0]     sys_hz;
    logic [DIV_W-1:0]     periph_hz;
    logic [SPLIT_PROD_W-1:0] split_prod;
    logic [TICKS_W-1:0]   low_raw;
    logic [TICKS_W-1:0]   high_raw;
    logic [7:0]           low_fld;
    logic [7:0]           high_fld;
    logic [3:0]           cdel;
    div_req_t             div_req;
    div_rsp_t             div_rsp;

    // Peripheral clock: both prescalers are powers of two
    assign sys_hz    = (clk_src_reg == CLK_SRC_PLL) ? SYS_CLK_FAST : SYS_CLK_SLOW;
    assign periph_hz = sys_hz >> (ahb_shift(ahb_code_reg) + apb_shift(apb_code_reg));

    // Split ticks into low and high time, clamp each field
    assign split_prod = SPLIT_PROD_W'({ticks_reg, 1'b0}) * SPLIT_RECIP;
    assign low_raw  = TICKS_W'(split_prod >> SPLIT_SHIFT);
    assign high_raw = ticks_reg - low_raw;
    assign low_fld  = (low_raw > FIELD_MAX) ? FIELD_MAX[7:0] : low_raw[7:0];
    assign high_fld = (high_raw > FIELD_MAX) ? FIELD_MAX[7:0] : high_raw[7:0];
    assign cdel     = (speed_reg <= STD_MODE_LIMIT) ? CDEL_STD : CDEL_FAST;

    always_comb
    begin
        state_next     = state_reg;
        start_next     = 1'b0;
        out_valid_next = out_valid_reg;
        dividend_next  = dividend_reg;
        divisor_next   = divisor_reg;
        speed_next     = speed_reg;
        clk_ns_next    = clk_ns_reg;
        bus_ns_next    = bus_ns_reg;
        acc_next       = acc_reg;
        presc_next     = presc_reg;
        ticks_next     = ticks_reg;
        res_word_next  = res_word_reg;
        res_ok_next    = res_ok_reg;
        word_next      = word_reg;
        possible_next  = possible_reg;

        // Drop the result once it is taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    speed_next = speed_hz;
                    if (speed_hz == '0)
                    begin
                        res_word_next = '0;
                        res_ok_next   = 1'b0;
                        state_next    = ST_FINISH;
                    end
                    else
                    begin
                        // Start the clock period division
                        dividend_next = NS_PER_SEC;
                        divisor_next  = periph_hz;
                        start_next    = 1'b1;
                        state_next    = ST_CLK;
                    end
                end
            end
            ST_CLK:
            begin
                if (div_rsp.done)
                begin
                    clk_ns_next   = div_rsp.quotient;
                    acc_next      = div_rsp.quotient;
                    dividend_next = NS_PER_SEC;
                    divisor_next  = {{(DIV_W-SPEED_W){1'b0}}, speed_reg};
                    start_next    = 1'b1;
                    state_next    = ST_BUS;
                end
            end
            ST_BUS:
            begin
                if (div_rsp.done)
                begin
                    bus_ns_next   = div_rsp.quotient;
                    presc_next    = '0;
                    dividend_next = div_rsp.quotient;
                    divisor_next  = acc_reg;
                    start_next    = 1'b1;
                    state_next    = ST_TICK;
                end
            end
            ST_TICK:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient <= MAX_TICKS)
                    begin
                        // Prescaler fits: split two-thirds low
                        ticks_next    = div_rsp.quotient[TICKS_W-1:0];
                        state_next    = ST_SPLIT;
                    end
                    else if (presc_reg == PRESC_LAST)
                    begin
                        res_word_next = '0;
                        res_ok_next   = 1'b0;
                        state_next    = ST_FINISH;
                    end
                    else
                    begin
                        // Advance to the next prescaler
                        presc_next    = presc_reg + 1'b1;
                        acc_next      = acc_reg + clk_ns_reg;
                        dividend_next = bus_ns_reg;
                        divisor_next  = acc_reg + clk_ns_reg;
                        start_next    = 1'b1;
                    end
                end
            end
            ST_SPLIT:
            begin
                res_word_next = {presc_reg, 4'b0000, cdel, 4'b0000, high_fld, low_fld};
                res_ok_next   = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_FINISH:
            begin
                // Load the output register once it is free
                if (!out_valid_reg || !out_stall)
                begin
                    word_next      = res_word_reg;
                    possible_next  = res_ok_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            clk_src_reg   <= '0;
            ahb_code_reg  <= '0;
            apb_code_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CLOCK_SOURCE: clk_src_reg  <= cfg_data[1:0];
                    CFG_AHB_PRESCALE: ahb_code_reg <= cfg_data[3:0];
                    CFG_APB_PRESCALE: apb_code_reg <= cfg_data[2:0];
                    default:          ;
                endcase
            end
        end
    end

    // Hold operands and results
    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        speed_reg    <= speed_next;
        clk_ns_reg   <= clk_ns_next;
        bus_ns_reg   <= bus_ns_next;
        acc_reg      <= acc_next;
        presc_reg    <= presc_next;
        ticks_reg    <= ticks_next;
        res_word_reg <= res_word_next;
        res_ok_reg   <= res_ok_next;
        word_reg     <= word_next;
        possible_reg <= possible_next;
    end

    assign div_req.start    = start_reg;
    assign div_req.dividend = dividend_reg;
    assign div_req.divisor  = divisor_reg;

    i2ctw_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign timing_word = word_reg;
    assign possible    = possible_reg;

    // An impossible result carries a zero word
    a_impossible_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !possible |-> timing_word == '0)
        else $error("impossible result with nonzero timing word");

    // A valid word has zero reserved and data delay bits and a legal clock delay
    a_word_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && possible |-> timing_word[27:24] == 4'd0 &&
            timing_word[19:16] == 4'd0 &&
            (timing_word[23:20] == CDEL_STD || timing_word[23:20] == CDEL_FAST))
        else $error("malformed timing word fields");

    // The divider finishes only while the sequencer waits on it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_CLK || state_reg == ST_BUS ||
            state_reg == ST_TICK))
        else $error("divider done outside a wait state");

    // A start never arrives while a division is finishing
    a_no_start_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> !div_rsp.done)
        else $error("divider restarted on its done cycle");

endmodule
